>>> design/ases_pkg.sv
// shared constants, codes and types of the accumulator and stack execute unit
package ases_pkg;

	localparam int DATA_W      = 32;
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int STEP_W      = $clog2(DATA_W);
	localparam int PC_W        = 16;

	localparam logic [3:0] CMD_ADD  = 4'd0;
	localparam logic [3:0] CMD_SUB  = 4'd1;
	localparam logic [3:0] CMD_MUL  = 4'd2;
	localparam logic [3:0] CMD_DIV  = 4'd3;
	localparam logic [3:0] CMD_PUSH = 4'd4;
	localparam logic [3:0] CMD_POP  = 4'd5;
	localparam logic [3:0] CMD_STOR = 4'd6;
	localparam logic [3:0] CMD_LOAD = 4'd7;
	localparam logic [3:0] CMD_JMP  = 4'd8;
	localparam logic [3:0] CMD_JE   = 4'd9;
	localparam logic [3:0] CMD_JNE  = 4'd10;
	localparam logic [3:0] CMD_JL   = 4'd11;
	localparam logic [3:0] CMD_JLE  = 4'd12;
	localparam logic [3:0] CMD_JG   = 4'd13;
	localparam logic [3:0] CMD_JGE  = 4'd14;
	localparam logic [3:0] CMD_CMP  = 4'd15;

	localparam logic [2:0] FAULT_NONE      = 3'd0;
	localparam logic [2:0] FAULT_UNDERFLOW = 3'd1;
	localparam logic [2:0] FAULT_BAD_JUMP  = 3'd2;
	localparam logic [2:0] FAULT_BAD_FORM  = 3'd3;
	localparam logic [2:0] FAULT_OVERFLOW  = 3'd4;
	localparam logic [2:0] FAULT_DIV_ZERO  = 3'd5;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} alu_rsp_t;

endpackage

>>> design/ases_alu.sv
// shared arithmetic unit: add, sub and mul registered, signed divide one bit a cycle
module ases_alu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ases_pkg::alu_req_t          req,
	input  logic [ases_pkg::DATA_W-1:0] a,
	input  logic [ases_pkg::DATA_W-1:0] b,
	output ases_pkg::alu_rsp_t          rsp,
	output logic [ases_pkg::DATA_W-1:0] result
);

	typedef enum logic {
		A_IDLE,
		A_DIV
	} alu_state_t;

	alu_state_t                        state_q;
	logic [ases_pkg::DATA_W-1:0]       rem_q;
	logic [ases_pkg::DATA_W-1:0]       quo_q;
	logic [ases_pkg::DATA_W-1:0]       div_q;
	logic                              sgn_q;
	logic [ases_pkg::STEP_W-1:0]       step_q;
	logic [ases_pkg::DATA_W:0]         trial;
	logic [ases_pkg::DATA_W-1:0]       rem_nx;
	logic [ases_pkg::DATA_W-1:0]       quo_nx;
	logic [ases_pkg::DATA_W-1:0]       mag_a;
	logic [ases_pkg::DATA_W-1:0]       mag_b;

	assign mag_a = a[ases_pkg::DATA_W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[ases_pkg::DATA_W-1] ? (~b + 1'b1) : b;
	assign trial = {rem_q, quo_q[ases_pkg::DATA_W-1]} - {1'b0, div_q};

	always_comb begin
		if (!trial[ases_pkg::DATA_W]) begin
			rem_nx = trial[ases_pkg::DATA_W-1:0];
			quo_nx = {quo_q[ases_pkg::DATA_W-2:0], 1'b1};
		end else begin
			rem_nx = {rem_q[ases_pkg::DATA_W-2:0], quo_q[ases_pkg::DATA_W-1]};
			quo_nx = {quo_q[ases_pkg::DATA_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= A_IDLE;
			rsp.done <= 1'b0;
			rsp.zero <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						rsp.zero <= 1'b0;
						case (req.op)
							ases_pkg::ALU_ADD: begin
								result   <= a + b;
								rsp.done <= 1'b1;
							end
							ases_pkg::ALU_SUB: begin
								result   <= a - b;
								rsp.done <= 1'b1;
							end
							ases_pkg::ALU_MUL: begin
								result   <= a * b;
								rsp.done <= 1'b1;
							end
							default: begin
								if (b == '0) begin
									result   <= '0;
									rsp.zero <= 1'b1;
									rsp.done <= 1'b1;
								end else begin
									rem_q   <= '0;
									quo_q   <= mag_a;
									div_q   <= mag_b;
									sgn_q   <= a[ases_pkg::DATA_W-1] ^ b[ases_pkg::DATA_W-1];
									step_q  <= '0;
									state_q <= A_DIV;
								end
							end
						endcase
					end
				end
				A_DIV: begin
					rem_q  <= rem_nx;
					quo_q  <= quo_nx;
					step_q <= step_q + 1'b1;
					if (step_q == ases_pkg::STEP_W'(ases_pkg::DATA_W - 1)) begin
						result   <= sgn_q ? (~quo_nx + 1'b1) : quo_nx;
						rsp.done <= 1'b1;
						state_q  <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

>>> design/ases_stack.sv
// stack storage: one write port, one read port with registered data
module ases_stack (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ases_pkg::ADDR_W-1:0] wr_addr,
	input  logic [ases_pkg::DATA_W-1:0] wr_data,
	input  logic [ases_pkg::ADDR_W-1:0] rd_addr,
	output logic [ases_pkg::DATA_W-1:0] rd_data
);

	logic [ases_pkg::DATA_W-1:0] mem_q [ases_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> design/accumulator_stack_execute_unit.sv
// top level: instruction sequencer around the shared arithmetic unit and the stack
//
// channel  direction  handshake              word
// op       in         op_valid / op_stall    cmd, form, operand values, label, is_compare
// res      out        res_valid / res_stall  dest, accumulator, jump, flags, fault
// cfg      in         cfg_valid / cfg_ready  program_length
//
// one word at a time; add, sub, mul, div and compares wait on the arithmetic unit, and div
// takes longest, set by the one-bit-a-cycle divider.
// stack operands come out of the stack memory one read per cycle.
// reset clears accumulator, flags, stack count and program_length; no clearing pass.
// a stalled result holds the sequencer in its last step; cfg_ready is always high.
module accumulator_stack_execute_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   op_valid,
	output logic                                   op_stall,
	input  logic [3:0]                             cmd,
	input  logic [1:0]                             form,
	input  logic signed [ases_pkg::DATA_W-1:0]     first_value,
	input  logic signed [ases_pkg::DATA_W-1:0]     second_value,
	input  logic signed [ases_pkg::DATA_W-1:0]     third_value,
	input  logic                                   label_found,
	input  logic [ases_pkg::PC_W-1:0]              label_target,
	input  logic                                   is_compare,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic                                   dest_write,
	output logic signed [ases_pkg::DATA_W-1:0]     dest_value,
	output logic signed [ases_pkg::DATA_W-1:0]     accumulator,
	output logic                                   jump_taken,
	output logic [ases_pkg::PC_W-1:0]              jump_target,
	output logic                                   eq_flag,
	output logic                                   neg_flag,
	output logic [2:0]                             fault,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ases_pkg::PC_W-1:0]              cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_RDB,
		S_RDA,
		S_POP,
		S_GO,
		S_WAIT,
		S_OUT
	} seq_state_t;

	seq_state_t                    state_q;
	logic [3:0]                    cmd_q;
	logic [1:0]                    form_q;
	logic [ases_pkg::DATA_W-1:0]   v1_q, v2_q, v3_q;
	logic                          found_q;
	logic [ases_pkg::PC_W-1:0]     target_q;
	logic                          cmp_q;
	logic [ases_pkg::DATA_W-1:0]   acc_q;
	logic [ases_pkg::CNT_W-1:0]    count_q;
	logic                          eq_q, neg_q;
	logic [ases_pkg::PC_W-1:0]     plen_q;
	logic                          dw_q, jt_q;
	logic [ases_pkg::DATA_W-1:0]   dv_q;
	logic [ases_pkg::PC_W-1:0]     jtg_q;
	logic [2:0]                    fault_q;
	logic [ases_pkg::DATA_W-1:0]   opa_q, opb_q;
	ases_pkg::alu_op_t             aop_q;
	ases_pkg::alu_req_t            alu_req;
	ases_pkg::alu_rsp_t            alu_rsp;
	logic [ases_pkg::DATA_W-1:0]   alu_res;
	logic                          wr_en;
	logic [ases_pkg::ADDR_W-1:0]   wr_addr;
	logic [ases_pkg::DATA_W-1:0]   wr_data;
	logic [ases_pkg::ADDR_W-1:0]   rd_addr;
	logic [ases_pkg::DATA_W-1:0]   rd_data;
	logic [ases_pkg::CNT_W-1:0]    cnt_m1, cnt_m2;
	logic                          cond;
	logic                          is_cmp;

	assign cfg_ready = 1'b1;
	assign op_stall  = (state_q != S_IDLE);
	assign cnt_m1    = count_q - 1'b1;
	assign cnt_m2    = count_q - 2'd2;
	assign is_cmp    = cmp_q || (cmd_q == ases_pkg::CMD_CMP);
	assign rd_addr   = (state_q == S_RDB) ? cnt_m2[ases_pkg::ADDR_W-1:0]
		: cnt_m1[ases_pkg::ADDR_W-1:0];

	assign alu_req.start = (state_q == S_GO);
	assign alu_req.op    = aop_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ases_pkg::ADDR_W-1:0];
		wr_data = (form_q == 2'd0) ? acc_q : v1_q;
		if (state_q == S_DEC && !is_cmp && cmd_q == ases_pkg::CMD_PUSH && form_q <= 2'd1
			&& count_q < ases_pkg::CNT_W'(ases_pkg::STACK_DEPTH)) begin
			wr_en = 1'b1;
		end else if (state_q == S_WAIT && alu_rsp.done && !alu_rsp.zero && !is_cmp
			&& form_q == 2'd0) begin
			wr_en   = 1'b1;
			wr_addr = cnt_m2[ases_pkg::ADDR_W-1:0];
			wr_data = alu_res;
		end
	end

	always_comb begin
		case (cmd_q)
			ases_pkg::CMD_JMP: cond = 1'b1;
			ases_pkg::CMD_JE:  cond = eq_q;
			ases_pkg::CMD_JNE: cond = !eq_q;
			ases_pkg::CMD_JL:  cond = !eq_q && neg_q;
			ases_pkg::CMD_JLE: cond = eq_q || neg_q;
			ases_pkg::CMD_JG:  cond = !eq_q && !neg_q;
			default:           cond = eq_q || !neg_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			acc_q     <= '0;
			count_q   <= '0;
			eq_q      <= 1'b0;
			neg_q     <= 1'b0;
			plen_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				plen_q <= cfg_data;
			end
			if (res_valid && !res_stall && state_q != S_OUT) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						cmd_q    <= cmd;
						form_q   <= form;
						v1_q     <= first_value;
						v2_q     <= second_value;
						v3_q     <= third_value;
						found_q  <= label_found;
						target_q <= label_target;
						cmp_q    <= is_compare;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					dw_q    <= 1'b0;
					dv_q    <= '0;
					jt_q    <= 1'b0;
					jtg_q   <= '0;
					fault_q <= ases_pkg::FAULT_NONE;
					state_q <= S_OUT;
					if (is_cmp) begin
						aop_q <= ases_pkg::ALU_SUB;
						opa_q <= (form_q == 2'd1) ? acc_q : v1_q;
						opb_q <= (form_q == 2'd1) ? v1_q : v2_q;
						if (form_q == 2'd1 || form_q == 2'd2) begin
							state_q <= S_GO;
						end else begin
							fault_q <= ases_pkg::FAULT_BAD_FORM;
						end
					end else begin
						case (cmd_q)
							ases_pkg::CMD_ADD, ases_pkg::CMD_SUB,
							ases_pkg::CMD_MUL, ases_pkg::CMD_DIV: begin
								aop_q <= ases_pkg::alu_op_t'(cmd_q[1:0]);
								case (form_q)
									2'd0: begin
										if (count_q < ases_pkg::CNT_W'(2)) begin
											fault_q <= ases_pkg::FAULT_UNDERFLOW;
										end else begin
											state_q <= S_RDB;
										end
									end
									2'd1: begin
										opa_q   <= acc_q;
										opb_q   <= v1_q;
										state_q <= S_GO;
									end
									2'd2: begin
										opa_q   <= v1_q;
										opb_q   <= v2_q;
										state_q <= S_GO;
									end
									default: begin
										opa_q   <= v2_q;
										opb_q   <= v3_q;
										state_q <= S_GO;
									end
								endcase
							end
							ases_pkg::CMD_PUSH: begin
								if (form_q > 2'd1) begin
									fault_q <= ases_pkg::FAULT_BAD_FORM;
								end else if (count_q >=
									ases_pkg::CNT_W'(ases_pkg::STACK_DEPTH)) begin
									fault_q <= ases_pkg::FAULT_OVERFLOW;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							ases_pkg::CMD_POP: begin
								if (form_q != 2'd0) begin
									fault_q <= ases_pkg::FAULT_BAD_FORM;
								end else if (count_q == '0) begin
									fault_q <= ases_pkg::FAULT_UNDERFLOW;
								end else begin
									state_q <= S_POP;
								end
							end
							ases_pkg::CMD_STOR, ases_pkg::CMD_LOAD: begin
								if (form_q == 2'd1) begin
									if (cmd_q == ases_pkg::CMD_STOR) begin
										dw_q <= 1'b1;
										dv_q <= acc_q;
									end else begin
										acc_q <= v1_q;
									end
								end else if (form_q == 2'd2) begin
									dw_q <= 1'b1;
									dv_q <= v2_q;
								end else begin
									fault_q <= ases_pkg::FAULT_BAD_FORM;
								end
							end
							default: begin
								if (form_q != 2'd1) begin
									fault_q <= ases_pkg::FAULT_BAD_FORM;
								end else if (cond) begin
									if (!found_q || target_q >= plen_q) begin
										fault_q <= ases_pkg::FAULT_BAD_JUMP;
									end else begin
										jt_q  <= 1'b1;
										jtg_q <= target_q;
									end
								end
							end
						endcase
					end
				end
				S_RDB: begin
					opb_q   <= rd_data;
					state_q <= S_RDA;
				end
				S_RDA: begin
					opa_q   <= rd_data;
					state_q <= S_GO;
				end
				S_POP: begin
					acc_q   <= rd_data;
					count_q <= cnt_m1;
					state_q <= S_OUT;
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						state_q <= S_OUT;
						if (alu_rsp.zero) begin
							fault_q <= ases_pkg::FAULT_DIV_ZERO;
						end else if (is_cmp) begin
							eq_q  <= (alu_res == '0);
							neg_q <= alu_res[ases_pkg::DATA_W-1];
						end else begin
							case (form_q)
								2'd0: count_q <= cnt_m1;
								2'd1: acc_q   <= alu_res;
								default: begin
									dw_q <= 1'b1;
									dv_q <= alu_res;
								end
							endcase
						end
					end
				end
				S_OUT: begin
					if (!res_valid || !res_stall) begin
						res_valid   <= 1'b1;
						dest_write  <= dw_q;
						dest_value  <= dv_q;
						accumulator <= acc_q;
						jump_taken  <= jt_q;
						jump_target <= jtg_q;
						eq_flag     <= eq_q;
						neg_flag    <= neg_q;
						fault       <= fault_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ases_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opa_q),
		.b      (opb_q),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	ases_stack u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

>>> design/ases_checker.sv
// port checker for the execute unit and its bind
module ases_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               op_valid,
	input logic                               op_stall,
	input logic                               res_valid,
	input logic                               res_stall,
	input logic                               dest_write,
	input logic [ases_pkg::DATA_W-1:0]        dest_value,
	input logic                               jump_taken,
	input logic [ases_pkg::PC_W-1:0]          jump_target,
	input logic [2:0]                         fault
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(fault) && $stable(dest_value))
		else $error("stalled result word changed");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fault != ases_pkg::FAULT_NONE |-> !dest_write && !jump_taken)
		else $error("faulted word writes or jumps");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (dest_write || dest_value == '0) && (jump_taken || jump_target == '0))
		else $error("unused result field not zero");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("second word taken before first finished");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> fault <= ases_pkg::FAULT_DIV_ZERO)
		else $error("undefined fault code");

endmodule

bind accumulator_stack_execute_unit ases_checker u_ases_checker (.*);

>>> tb/sv/accumulator_stack_execute_unit_tb.sv
// self-checking testbench of the accumulator and stack execute unit with random stimulus and stalls
`timescale 1ns / 1ps

module accumulator_stack_execute_unit_tb;

	typedef struct {
		logic [3:0]  cmd;
		logic [1:0]  form;
		logic [31:0] v1;
		logic [31:0] v2;
		logic [31:0] v3;
		logic        found;
		logic [15:0] target;
		logic        is_cmp;
	} instr_t;

	typedef struct {
		logic        dw;
		logic [31:0] dv;
		logic [31:0] acc;
		logic        jt;
		logic [15:0] jtgt;
		logic        eq;
		logic        neg;
		logic [2:0]  flt;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	logic [3:0] cmd = '0;
	logic [1:0] form = '0;
	logic signed [31:0] first_value = '0;
	logic signed [31:0] second_value = '0;
	logic signed [31:0] third_value = '0;
	logic label_found = 1'b0;
	logic [15:0] label_target = '0;
	logic is_compare = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic dest_write;
	logic signed [31:0] dest_value;
	logic signed [31:0] accumulator;
	logic jump_taken;
	logic [15:0] jump_target;
	logic eq_flag;
	logic neg_flag;
	logic [2:0] fault;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	accumulator_stack_execute_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall),
		.cmd(cmd), .form(form), .first_value(first_value),
		.second_value(second_value), .third_value(third_value),
		.label_found(label_found), .label_target(label_target), .is_compare(is_compare),
		.res_valid(res_valid), .res_stall(res_stall),
		.dest_write(dest_write), .dest_value(dest_value), .accumulator(accumulator),
		.jump_taken(jump_taken), .jump_target(jump_target),
		.eq_flag(eq_flag), .neg_flag(neg_flag), .fault(fault),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	logic [31:0] m_acc;
	logic [31:0] m_stack [ases_pkg::STACK_DEPTH];
	int          m_count;
	logic        m_eq, m_neg;
	logic [15:0] m_plen;

	instr_t   pending_words[$];
	outcome_t expected_words[$];
	int       mismatches = 0;
	int       cycles = 0;
	bit       hold_off = 1'b0;

	function automatic logic [31:0] arith(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		case (op)
			ases_pkg::CMD_ADD: return a + b;
			ases_pkg::CMD_SUB: return a - b;
			ases_pkg::CMD_MUL: return a * b;
			default: begin
				ma = a[31] ? -a : a;
				mb = b[31] ? -b : b;
				q = ma / mb;
				return (a[31] != b[31]) ? -q : q;
			end
		endcase
	endfunction

	function automatic outcome_t execute(instr_t w);
		outcome_t o;
		logic [31:0] x, y, diff;
		logic cond;
		o = '{default: '0};
		if (w.is_cmp || w.cmd == ases_pkg::CMD_CMP) begin
			if (w.form == 1 || w.form == 2) begin
				diff = (w.form == 1) ? m_acc - w.v1 : w.v1 - w.v2;
				m_eq = (diff == 0);
				m_neg = diff[31];
			end else o.flt = ases_pkg::FAULT_BAD_FORM;
		end else if (w.cmd <= ases_pkg::CMD_DIV) begin
			if (w.form == 0) begin
				x = m_stack[m_count - 2 < 0 ? 0 : m_count - 2];
				y = m_stack[m_count - 1 < 0 ? 0 : m_count - 1];
			end else if (w.form == 1) begin
				x = m_acc; y = w.v1;
			end else if (w.form == 2) begin
				x = w.v1; y = w.v2;
			end else begin
				x = w.v2; y = w.v3;
			end
			if (w.form == 0 && m_count < 2) o.flt = ases_pkg::FAULT_UNDERFLOW;
			else if (w.cmd == ases_pkg::CMD_DIV && y == 0) o.flt = ases_pkg::FAULT_DIV_ZERO;
			else if (w.form == 0) begin
				m_stack[m_count - 2] = arith(w.cmd, x, y);
				m_count--;
			end else if (w.form == 1) m_acc = arith(w.cmd, x, y);
			else begin
				o.dw = 1'b1; o.dv = arith(w.cmd, x, y);
			end
		end else if (w.cmd == ases_pkg::CMD_PUSH) begin
			if (w.form > 1) o.flt = ases_pkg::FAULT_BAD_FORM;
			else if (m_count >= ases_pkg::STACK_DEPTH) o.flt = ases_pkg::FAULT_OVERFLOW;
			else begin
				m_stack[m_count] = (w.form == 0) ? m_acc : w.v1;
				m_count++;
			end
		end else if (w.cmd == ases_pkg::CMD_POP) begin
			if (w.form != 0) o.flt = ases_pkg::FAULT_BAD_FORM;
			else if (m_count < 1) o.flt = ases_pkg::FAULT_UNDERFLOW;
			else begin
				m_count--;
				m_acc = m_stack[m_count];
			end
		end else if (w.cmd == ases_pkg::CMD_STOR || w.cmd == ases_pkg::CMD_LOAD) begin
			if (w.form == 1) begin
				if (w.cmd == ases_pkg::CMD_STOR) begin
					o.dw = 1'b1; o.dv = m_acc;
				end else m_acc = w.v1;
			end else if (w.form == 2) begin
				o.dw = 1'b1; o.dv = w.v2;
			end else o.flt = ases_pkg::FAULT_BAD_FORM;
		end else begin
			if (w.form != 1) o.flt = ases_pkg::FAULT_BAD_FORM;
			else begin
				case (w.cmd)
					ases_pkg::CMD_JMP: cond = 1'b1;
					ases_pkg::CMD_JE:  cond = m_eq;
					ases_pkg::CMD_JNE: cond = !m_eq;
					ases_pkg::CMD_JL:  cond = !m_eq && m_neg;
					ases_pkg::CMD_JLE: cond = m_eq || m_neg;
					ases_pkg::CMD_JG:  cond = !m_eq && !m_neg;
					default:           cond = m_eq || !m_neg;
				endcase
				if (cond) begin
					if (!w.found || w.target >= m_plen) o.flt = ases_pkg::FAULT_BAD_JUMP;
					else begin
						o.jt = 1'b1; o.jtgt = w.target;
					end
				end
			end
		end
		o.acc = m_acc;
		o.eq = m_eq;
		o.neg = m_neg;
		return o;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 3);
			4: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t rand_instr();
		instr_t w;
		w.cmd = 4'($urandom_range(0, 15));
		w.form = 2'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) :
			(w.cmd <= ases_pkg::CMD_DIV) ? $urandom_range(0, 3) :
			(w.cmd == ases_pkg::CMD_PUSH) ? $urandom_range(0, 1) :
			(w.cmd == ases_pkg::CMD_POP) ? 0 :
			(w.cmd == ases_pkg::CMD_STOR || w.cmd == ases_pkg::CMD_LOAD
			|| w.cmd == ases_pkg::CMD_CMP) ? $urandom_range(1, 2) : 1);
		if (w.cmd <= ases_pkg::CMD_POP && $urandom_range(0, 2) == 0)
			w.cmd = $urandom_range(0, 1) ? ases_pkg::CMD_PUSH : ases_pkg::CMD_POP;
		w.v1 = rand_value();
		w.v2 = rand_value();
		w.v3 = rand_value();
		w.found = ($urandom_range(0, 5) != 0);
		w.target = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300));
		w.is_cmp = ($urandom_range(0, 15) == 0);
		return w;
	endfunction

	function automatic instr_t mk(logic [3:0] c, logic [1:0] f, logic [31:0] a,
		logic [31:0] b, logic [31:0] d, logic fnd, logic [15:0] t);
		instr_t w;
		w.cmd = c; w.form = f; w.v1 = a; w.v2 = b; w.v3 = d;
		w.found = fnd; w.target = t; w.is_cmp = 1'b0;
		return w;
	endfunction

	task automatic drain_and_config(logic [15:0] v);
		while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		m_plen = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	logic op_stall_seen = 1'b1;
	always @(posedge clk) op_stall_seen <= !(op_valid && !op_stall) ? 1'b1 : 1'b0;

	// driver
	int     send_gap = 0;
	instr_t cur;
	always @(negedge clk) begin
		if (op_valid && !op_stall_seen) begin
			op_valid <= 1'b0;
			send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
		end else if (!op_valid) begin
			if (send_gap > 0) send_gap--;
			else if (pending_words.size() != 0 && arst_n) begin
				cur = pending_words.pop_front();
				expected_words.push_back(execute(cur));
				cmd <= cur.cmd; form <= cur.form;
				first_value <= cur.v1; second_value <= cur.v2; third_value <= cur.v3;
				label_found <= cur.found; label_target <= cur.target;
				is_compare <= cur.is_cmp;
				op_valid <= 1'b1;
			end
		end
	end

	// receiver stall
	int recv_gap = 0;
	always @(negedge clk) begin
		if (hold_off) res_stall <= 1'b1;
		else if (res_valid && !res_stall) begin
			recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
			res_stall <= (recv_gap != 0);
		end else if (recv_gap > 0) begin
			recv_gap--;
			res_stall <= (recv_gap != 0);
		end else res_stall <= 1'b0;
	end

	// monitor
	outcome_t exp_w;
	always @(posedge clk) begin
		cycles++;
		if (res_valid && !res_stall && arst_n) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
			end else begin
				exp_w = expected_words.pop_front();
				if (dest_write !== exp_w.dw || dest_value !== exp_w.dv ||
					accumulator !== exp_w.acc || jump_taken !== exp_w.jt ||
					jump_target !== exp_w.jtgt || eq_flag !== exp_w.eq ||
					neg_flag !== exp_w.neg || fault !== exp_w.flt) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch cycle %0d: exp dw %0b dv %h acc %h jt %0b jtgt %0d",
							cycles, exp_w.dw, exp_w.dv, exp_w.acc, exp_w.jt, exp_w.jtgt);
						$write(" eq %0b neg %0b flt %0d,", exp_w.eq, exp_w.neg, exp_w.flt);
						$write(" got dw %0b dv %h acc %h jt %0b jtgt %0d",
							dest_write, dest_value, accumulator, jump_taken, jump_target);
						$display(" eq %0b neg %0b flt %0d", eq_flag, neg_flag, fault);
					end
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		repeat (3000) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		repeat (1500000) @(posedge clk);
		$display("** accumulator_stack_execute_unit: FAILED **");
		$finish;
	end

	initial begin
		m_acc = '0; m_count = 0; m_eq = 1'b0; m_neg = 1'b0; m_plen = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drain_and_config(16'd100);
		pending_words.push_back(mk(ases_pkg::CMD_POP, 0, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_ADD, 0, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_LOAD, 1, 32'h8000_0000, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_PUSH, 0, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_PUSH, 1, 32'hffff_ffff, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_DIV, 0, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_DIV, 2, 5, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_DIV, 3, 0, -7, 2, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_MUL, 2, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_SUB, 1, 32'h7fff_ffff, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_STOR, 1, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_STOR, 2, 0, 32'h1234_5678, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_LOAD, 3, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_POP, 1, 0, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_CMP, 2, 3, 3, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_JE, 1, 0, 0, 0, 1, 99));
		pending_words.push_back(mk(ases_pkg::CMD_JNE, 1, 0, 0, 0, 1, 5));
		pending_words.push_back(mk(ases_pkg::CMD_JMP, 1, 0, 0, 0, 0, 5));
		pending_words.push_back(mk(ases_pkg::CMD_JMP, 1, 0, 0, 0, 1, 100));
		pending_words.push_back(mk(ases_pkg::CMD_JMP, 2, 0, 0, 0, 1, 5));
		pending_words.push_back(mk(ases_pkg::CMD_CMP, 1, 32'h7fff_ffff, 0, 0, 1, 0));
		pending_words.push_back(mk(ases_pkg::CMD_JL, 1, 0, 0, 0, 1, 1));
		pending_words.push_back(mk(ases_pkg::CMD_JGE, 1, 0, 0, 0, 1, 2));
		pending_words.push_back(mk(ases_pkg::CMD_CMP, 3, 0, 0, 0, 1, 0));
		for (int i = 0; i < 66; i++)
			pending_words.push_back(mk(ases_pkg::CMD_PUSH, 1, i, 0, 0, 1, 0));
		for (int p = 0; p < 4; p++) begin
			drain_and_config(p == 0 ? 16'd0 : p == 1 ? 16'hffff : p == 2 ? 16'd1 : 16'd200);
			for (int i = 0; i < 250; i++) pending_words.push_back(rand_instr());
		end
		while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("** accumulator_stack_execute_unit: PASSED **");
		else
			$display("** accumulator_stack_execute_unit: FAILED **");
		$finish;
	end

endmodule
